// ===== hdl/tcw_pkg.sv =====
// Shared constants and cell-store request types for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int RAW_COLS     = 80;
  localparam int RAW_ROWS     = 25;
  localparam int LOGICAL_COLS = 40;
  localparam int LOGICAL_ROWS = 50;

  localparam int CELL_COUNT = RAW_COLS * RAW_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CELL_W     = 16;

  // request kinds
  localparam logic [1:0] K_PUT   = 2'd0;
  localparam logic [1:0] K_READ  = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;
  localparam logic [1:0] K_WRITE = 2'd3;

  // control characters handled by a put request
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result status
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // write port request into the cell store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } cell_wr_t;

  // read port request; data comes back registered, in the next cycle
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } cell_rd_t;

endpackage
`default_nettype wire

// ===== hdl/text_console_writer_top.sv =====
// Top level of the text console writer: command sequencer around the cell store.
//
// Usage: present a request on in_kind, in_char_code, in_attr_in, in_pos_x and
// in_pos_y with start high; the request is taken at the clock edge where
// start is high and busy is low. Kinds: put character at cursor, read cell,
// clear screen, write cell at position. Every request produces exactly one
// result, shown for one cycle with out_valid high; the receiver cannot stall,
// so the result simply goes by.
// Steps: a write, a carriage return or a line feed that does not scroll
// finish in the command state; a mapped read waits for the registered data;
// a backspace writes its space in a state of its own; a printable character
// and each space of a tab are written in the put state. A new request may be
// taken in the strobe cycle. A line feed or a wrap on the last row scrolls the
// logical screen: one read and one write per cell of rows 1 to LOGICAL_ROWS-1,
// each cell moved up a row, then a drain state and a fill of the new bottom
// row with spaces. A clear writes all LOGICAL_ROWS*LOGICAL_COLS (2000) cells.
// The cell store has a single write port.
// Reset: the cursor goes to the top left and the store is swept to zero, one
// cell per cycle over all CELL_COUNT (2000) cells, with busy high meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_char_code,
  input  wire logic [7:0] in_attr_in,
  input  wire logic [7:0] in_pos_x,
  input  wire logic [7:0] in_pos_y,
  output logic            out_valid,
  output logic [7:0]      out_read_char,
  output logic [7:0]      out_read_attr,
  output logic [5:0]      out_cursor_col_out,
  output logic [5:0]      out_cursor_row_out,
  output logic            out_status
);

  localparam int LX_W = (LOGICAL_COLS > 1) ? $clog2(LOGICAL_COLS) : 1;
  localparam int LY_W = (LOGICAL_ROWS > 1) ? $clog2(LOGICAL_ROWS) : 1;

  localparam logic [5:0]        LAST_ROW  = 6'(LOGICAL_ROWS - 1);
  localparam logic [5:0]        LAST_COL  = 6'(LOGICAL_COLS - 1);
  localparam logic [5:0]        WRAP_COL  = 6'(LOGICAL_COLS);
  localparam logic [LX_W-1:0]   SCAN_XMAX = LX_W'(LOGICAL_COLS - 1);
  localparam logic [LY_W-1:0]   SCAN_YMAX = LY_W'(LOGICAL_ROWS - 1);
  localparam logic [ADDR_W-1:0] INIT_MAX  = ADDR_W'(CELL_COUNT - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CMD, S_RDWAIT, S_PUT, S_BSWR,
    S_SCROLL, S_DRAIN, S_FILL, S_CLEAR
  } state_t;

  typedef struct packed {
    logic              in_range;
    logic              ok;
    logic              low;
    logic [ADDR_W-1:0] idx;
  } cell_map_t;

  // Map a logical cell to the raw store; the lower half folds to the right.
  function automatic cell_map_t map_cell(input logic [7:0] x, input logic [7:0] y);
    cell_map_t   m;
    logic [8:0]  rx;
    logic [8:0]  ry;
    logic [16:0] lin;
    m.in_range = (9'(x) < 9'(LOGICAL_COLS)) && (9'(y) < 9'(LOGICAL_ROWS));
    m.low      = 9'(y) >= 9'(RAW_ROWS);
    rx         = m.low ? 9'(x) + 9'(LOGICAL_COLS) : 9'(x);
    ry         = m.low ? 9'(y) - 9'(RAW_ROWS) : 9'(y);
    m.ok       = m.in_range && (rx < 9'(RAW_COLS)) && (ry < 9'(RAW_ROWS));
    lin        = 17'(rx) + 17'(ry) * 17'(RAW_COLS);
    m.idx      = lin[ADDR_W-1:0];
    return m;
  endfunction

  function automatic logic [7:0] nib_swap(input logic [7:0] a);
    return {a[3:0], a[7:4]};
  endfunction

  // control
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] init_r, init_nxt;
  logic [5:0]        col_r, col_nxt;
  logic [5:0]        row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pv_r, pv_nxt;

  // request and scan payload
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic [7:0]        px_r, px_nxt;
  logic [7:0]        py_r, py_nxt;
  logic [2:0]        left_r, left_nxt;
  logic [7:0]        putc_r, putc_nxt;
  logic [LX_W-1:0]   sx_r, sx_nxt;
  logic [LY_W-1:0]   sy_r, sy_nxt;

  // scroll pipeline: the write stage follows the read in the next cycle
  logic              pw_ok_r, pw_ok_nxt;
  logic [ADDR_W-1:0] pw_idx_r, pw_idx_nxt;
  logic              pw_swap_r, pw_swap_nxt;
  logic              psrc_ok_r, psrc_ok_nxt;

  // result payload
  logic [7:0]        rchar_r, rchar_nxt;
  logic [7:0]        rattr_r, rattr_nxt;
  logic              status_r, status_nxt;

  cell_wr_t          wr_req;
  cell_wr_t          st_wr;
  cell_rd_t          rd_req;
  logic [CELL_W-1:0] rd_data;
  logic [7:0]        pipe_attr;
  logic [7:0]        pipe_char;

  cell_map_t m_pos;
  cell_map_t m_cur;
  cell_map_t m_src;
  cell_map_t m_dst;

  assign m_pos = map_cell(px_r, py_r);
  assign m_cur = map_cell(8'(col_r), 8'(row_r));
  assign m_src = map_cell(8'(sx_r), 8'(sy_r));
  assign m_dst = map_cell(8'(sx_r), 8'(sy_r) - 8'd1);

  // Scroll write data: an unmapped source reads as zero; swap the attribute
  // when source and destination sit on different halves.
  assign pipe_attr = !psrc_ok_r ? 8'h00 :
                     (pw_swap_r ? nib_swap(rd_data[15:8]) : rd_data[15:8]);
  assign pipe_char = psrc_ok_r ? rd_data[7:0] : 8'h00;

  // The scroll pipeline owns the write port while it has a request in flight.
  always_comb begin
    if (pv_r && pw_ok_r) begin
      wr_req.en   = 1'b1;
      wr_req.addr = pw_idx_r;
      wr_req.data = {pipe_attr, pipe_char};
    end else begin
      wr_req = st_wr;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = 1'b0;
    pv_nxt        = 1'b0;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    attr_nxt      = attr_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    left_nxt      = left_r;
    putc_nxt      = putc_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    pw_ok_nxt     = pw_ok_r;
    pw_idx_nxt    = pw_idx_r;
    pw_swap_nxt   = pw_swap_r;
    psrc_ok_nxt   = psrc_ok_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    status_nxt    = status_r;
    st_wr         = '0;
    rd_req        = '0;

    case (state_r)
      S_INIT: begin
        // zero the store one cell per cycle
        st_wr.en   = 1'b1;
        st_wr.addr = init_r;
        st_wr.data = '0;
        if (init_r == INIT_MAX) begin
          state_nxt = S_IDLE;
        end else begin
          init_nxt = init_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_nxt   = in_kind;
          char_nxt   = in_char_code;
          attr_nxt   = in_attr_in;
          px_nxt     = in_pos_x;
          py_nxt     = in_pos_y;
          rchar_nxt  = 8'h00;
          rattr_nxt  = 8'h00;
          status_nxt = ST_OK;
          state_nxt  = S_CMD;
        end
      end

      S_CMD: begin
        case (kind_r)
          K_PUT: begin
            case (char_r)
              CH_NL: begin
                col_nxt  = '0;
                left_nxt = '0;
                if (row_r == LAST_ROW) begin
                  sx_nxt = '0;
                  if (LOGICAL_ROWS > 1) begin
                    sy_nxt    = LY_W'(1);
                    state_nxt = S_SCROLL;
                  end else begin
                    sy_nxt    = SCAN_YMAX;
                    state_nxt = S_FILL;
                  end
                end else begin
                  row_nxt       = row_r + 6'd1;
                  out_valid_nxt = 1'b1;
                  state_nxt     = S_IDLE;
                end
              end
              CH_CR: begin
                col_nxt       = '0;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
              CH_TAB: begin
                left_nxt  = 3'd4 - {1'b0, col_r[1:0]};
                putc_nxt  = CH_SPACE;
                state_nxt = S_PUT;
              end
              CH_BS: begin
                if (col_r != 6'd0) begin
                  col_nxt = col_r - 6'd1;
                end else begin
                  col_nxt = LAST_COL;
                  if (row_r != 6'd0) begin
                    row_nxt = row_r - 6'd1;
                  end
                end
                state_nxt = S_BSWR;
              end
              default: begin
                left_nxt  = 3'd1;
                putc_nxt  = char_r;
                state_nxt = S_PUT;
              end
            endcase
          end
          K_READ: begin
            if (!m_pos.in_range) begin
              rchar_nxt     = CH_SPACE;
              rattr_nxt     = CH_SPACE;
              status_nxt    = ST_RANGE;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (!m_pos.ok) begin
              status_nxt    = ST_RANGE;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              rd_req.en   = 1'b1;
              rd_req.addr = m_pos.idx;
              state_nxt   = S_RDWAIT;
            end
          end
          K_CLEAR: begin
            sx_nxt    = '0;
            sy_nxt    = '0;
            state_nxt = S_CLEAR;
          end
          K_WRITE: begin
            st_wr.en      = m_pos.ok;
            st_wr.addr    = m_pos.idx;
            st_wr.data    = {m_pos.low ? nib_swap(attr_r) : attr_r, char_r};
            status_nxt    = m_pos.ok ? ST_OK : ST_RANGE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_RDWAIT: begin
        rchar_nxt     = rd_data[7:0];
        rattr_nxt     = m_pos.low ? nib_swap(rd_data[15:8]) : rd_data[15:8];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_BSWR: begin
        st_wr.en      = m_cur.ok;
        st_wr.addr    = m_cur.idx;
        st_wr.data    = {m_cur.low ? nib_swap(attr_r) : attr_r, CH_SPACE};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_PUT: begin
        if (left_r == 3'd0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (col_r >= WRAP_COL) begin
          // deferred wrap: new line first, scroll if on the last row
          col_nxt = '0;
          if (row_r == LAST_ROW) begin
            sx_nxt = '0;
            if (LOGICAL_ROWS > 1) begin
              sy_nxt    = LY_W'(1);
              state_nxt = S_SCROLL;
            end else begin
              sy_nxt    = SCAN_YMAX;
              state_nxt = S_FILL;
            end
          end else begin
            row_nxt = row_r + 6'd1;
          end
        end else begin
          st_wr.en   = m_cur.ok;
          st_wr.addr = m_cur.idx;
          st_wr.data = {m_cur.low ? nib_swap(attr_r) : attr_r, putc_r};
          col_nxt    = col_r + 6'd1;
          left_nxt   = left_r - 3'd1;
        end
      end

      S_SCROLL: begin
        // read cell (x, y), write it to (x, y-1) in the next cycle
        rd_req.en   = m_src.ok;
        rd_req.addr = m_src.idx;
        pv_nxt      = 1'b1;
        pw_ok_nxt   = m_dst.ok;
        pw_idx_nxt  = m_dst.idx;
        pw_swap_nxt = m_src.low ^ m_dst.low;
        psrc_ok_nxt = m_src.ok;
        if (sx_r == SCAN_XMAX) begin
          sx_nxt = '0;
          if (sy_r == SCAN_YMAX) begin
            state_nxt = S_DRAIN;
          end else begin
            sy_nxt = sy_r + LY_W'(1);
          end
        end else begin
          sx_nxt = sx_r + LX_W'(1);
        end
      end

      S_DRAIN: begin
        // let the last scroll write go through before filling
        state_nxt = S_FILL;
      end

      S_FILL: begin
        st_wr.en   = m_src.ok;
        st_wr.addr = m_src.idx;
        st_wr.data = {m_src.low ? nib_swap(attr_r) : attr_r, CH_SPACE};
        if (sx_r == SCAN_XMAX) begin
          state_nxt = S_PUT;
        end else begin
          sx_nxt = sx_r + LX_W'(1);
        end
      end

      S_CLEAR: begin
        st_wr.en   = m_src.ok;
        st_wr.addr = m_src.idx;
        st_wr.data = {m_src.low ? nib_swap(attr_r) : attr_r, char_r};
        if (sx_r == SCAN_XMAX) begin
          sx_nxt = '0;
          if (sy_r == SCAN_YMAX) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            sy_nxt = sy_r + LY_W'(1);
          end
        end else begin
          sx_nxt = sx_r + LX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      rchar_r     <= '0;
      rattr_r     <= '0;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      kind_r      <= kind_nxt;
      char_r      <= char_nxt;
      attr_r      <= attr_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      left_r      <= left_nxt;
      putc_r      <= putc_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      pw_ok_r     <= pw_ok_nxt;
      pw_idx_r    <= pw_idx_nxt;
      pw_swap_r   <= pw_swap_nxt;
      psrc_ok_r   <= psrc_ok_nxt;
      rchar_r     <= rchar_nxt;
      rattr_r     <= rattr_nxt;
      status_r    <= status_nxt;
    end
  end

  tcw_cell_store u_store (
    .clk     (clk),
    .wr      (wr_req),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_read_char      = rchar_r;
  assign out_read_attr      = rattr_r;
  assign out_cursor_col_out = col_r;
  assign out_cursor_row_out = row_r;
  assign out_status         = status_r;

  // a result strobe is never repeated back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // an accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // scroll write stage only runs behind the scroll read sweep
  a_pipe_owner: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_SCROLL || state_r == S_DRAIN))
    else $error("scroll write collides with a sequencer write");

  // cursor stays on the logical screen, column may rest at the wrap point
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (col_r <= WRAP_COL && row_r <= LAST_ROW))
    else $error("cursor off the logical screen");

  // only position-based requests report a range error
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_RANGE) |-> (kind_r == K_READ || kind_r == K_WRITE))
    else $error("range error flagged on a put or clear request");

endmodule
`default_nettype wire

// ===== hdl/tcw_cell_store.sv =====
// Cell store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcw_cell_store
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_wr_t          wr,
  input  wire cell_rd_t          rd,
  output logic      [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the text console writer: directed and random requests.
`timescale 1ns / 1ps
module tb_top
  import tcw_pkg::*;
();

  // ---------------------------------------------------------------------------
  // Request and result codes
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    KIND_PUT   = K_PUT,
    KIND_READ  = K_READ,
    KIND_CLEAR = K_CLEAR,
    KIND_WRITE = K_WRITE
  } console_kind_e;

  localparam logic [7:0] READ_MISS_FILL = 8'h20;

  localparam int LOOKUP_OK       = 0;
  localparam int LOOKUP_RANGE    = 1;
  localparam int LOOKUP_UNMAPPED = 2;

  localparam int TAB_STOP = 4;

  typedef struct {
    console_kind_e kind;
    logic [7:0]    char_code;
    logic [7:0]    attr;
    logic [7:0]    pos_x;
    logic [7:0]    pos_y;
  } console_req_t;

  typedef struct {
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic [5:0] col;
    logic [5:0] row;
    logic       status;
  } console_resp_t;

  // ---------------------------------------------------------------------------
  // Run shaping. Scrolls and clears each walk the whole store, so the random
  // part spends them from a fixed allowance.
  // ---------------------------------------------------------------------------
  localparam int RANDOM_ITEMS   = 1800;
  localparam int SCROLL_ALLOW   = 80;
  localparam int CLEAR_ALLOW    = 20;
  localparam int IDLE_PERCENT   = 31;
  localparam int MAX_GAP        = 8;
  localparam int QUIET_FIRST    = 600;   // no sender gaps in [QUIET_FIRST, QUIET_LAST)
  localparam int QUIET_LAST     = 900;
  localparam int PAUSE_EVERY    = 450;   // sender waits for every result this often
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  // Watchdog: room for every slow request (scroll or clear, a tab on top),
  // every other request at its longest gap plus latency, the reset sweep,
  // then four times that.
  localparam int SLOW_OPS_MAX   = SCROLL_ALLOW + CLEAR_ALLOW + 10;
  localparam int ITEMS_MAX      = RANDOM_ITEMS + 200;
  localparam int CYCLE_LIMIT    = 4 * (SLOW_OPS_MAX * 2100 + ITEMS_MAX * (MAX_GAP + 16)
                                       + CELL_COUNT + 100);

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_kind = '0;
  logic [7:0] in_char_code = '0;
  logic [7:0] in_attr_in = '0;
  logic [7:0] in_pos_x = '0;
  logic [7:0] in_pos_y = '0;

  logic       busy;
  logic       out_valid;
  logic [7:0] out_read_char;
  logic [7:0] out_read_attr;
  logic [5:0] out_cursor_col_out;
  logic [5:0] out_cursor_row_out;
  logic       out_status;

  always #2 clk = ~clk;

  text_console_writer_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_char_code       (in_char_code),
    .in_attr_in         (in_attr_in),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .out_valid          (out_valid),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_row_out (out_cursor_row_out),
    .out_status         (out_status)
  );

  // ---------------------------------------------------------------------------
  // Console shadow: our own copy of the cell store and the cursor
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_cells [CELL_COUNT];
  int          cur_col;
  int          cur_row;

  console_resp_t expected_results [$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            sender_gaps = 1'b1;
  int            scrolls_left = SCROLL_ALLOW;
  int            clears_left = CLEAR_ALLOW;

  // Rows in the lower logical half live in the right raw half with the
  // attribute nibbles swapped.
  function automatic logic [7:0] fold_attr(input logic [7:0] a);
    return {a[3:0], a[7:4]};
  endfunction

  function automatic bit locate_cell(input int x, input int y, output int idx);
    int rx;
    int ry;
    if (x >= LOGICAL_COLS || y >= LOGICAL_ROWS) return 1'b0;
    rx = x;
    ry = y;
    if (ry >= RAW_ROWS) begin
      rx += LOGICAL_COLS;
      ry -= RAW_ROWS;
    end
    if (rx >= RAW_COLS || ry >= RAW_ROWS) return 1'b0;
    idx = rx + ry * RAW_COLS;
    return 1'b1;
  endfunction

  function automatic bit store_glyph(input logic [7:0] c, input logic [7:0] a,
                                     input int x, input int y);
    int idx;
    if (!locate_cell(x, y, idx)) return 1'b0;
    shadow_cells[idx] = {(y >= RAW_ROWS) ? fold_attr(a) : a, c};
    return 1'b1;
  endfunction

  function automatic int fetch_glyph(input int x, input int y,
                                     output logic [7:0] c, output logic [7:0] a);
    int          idx;
    logic [15:0] cell_word;
    int          code;
    cell_word = '0;
    code = LOOKUP_OK;
    if (x >= LOGICAL_COLS || y >= LOGICAL_ROWS) begin
      c = READ_MISS_FILL;
      a = READ_MISS_FILL;
      return LOOKUP_RANGE;
    end
    if (locate_cell(x, y, idx)) cell_word = shadow_cells[idx];
    else code = LOOKUP_UNMAPPED;
    c = cell_word[7:0];
    a = (y >= RAW_ROWS) ? fold_attr(cell_word[15:8]) : cell_word[15:8];
    return code;
  endfunction

  function automatic void shift_screen_up(input logic [7:0] fill_attr);
    logic [7:0] c;
    logic [7:0] a;
    for (int y = 1; y < LOGICAL_ROWS; y++) begin
      for (int x = 0; x < LOGICAL_COLS; x++) begin
        void'(fetch_glyph(x, y, c, a));
        void'(store_glyph(c, a, x, y - 1));
      end
    end
    for (int x = 0; x < LOGICAL_COLS; x++)
      void'(store_glyph(CH_SPACE, fill_attr, x, LOGICAL_ROWS - 1));
  endfunction

  function automatic void advance_line(input logic [7:0] fill_attr);
    cur_col = 0;
    cur_row += 1;
    if (cur_row >= LOGICAL_ROWS) begin
      cur_row = LOGICAL_ROWS - 1;
      shift_screen_up(fill_attr);
    end
  endfunction

  // Deferred wrap: the column may rest one past the last; the next glyph
  // takes the line feed first.
  function automatic void emit_glyph(input logic [7:0] c, input logic [7:0] a);
    if (cur_col >= LOGICAL_COLS) advance_line(a);
    void'(store_glyph(c, a, cur_col, cur_row));
    cur_col++;
  endfunction

  function automatic void apply_put(input logic [7:0] c, input logic [7:0] a);
    int spaces;
    case (c)
      CH_NL: advance_line(a);
      CH_CR: cur_col = 0;
      CH_TAB: begin
        spaces = TAB_STOP - (cur_col % TAB_STOP);
        repeat (spaces) emit_glyph(CH_SPACE, a);
      end
      CH_BS: begin
        if (cur_col > 0) begin
          cur_col--;
        end else begin
          cur_col = LOGICAL_COLS - 1;
          if (cur_row > 0) cur_row--;
        end
        void'(store_glyph(CH_SPACE, a, cur_col, cur_row));
      end
      default: emit_glyph(c, a);
    endcase
  endfunction

  // Advance the shadow by one request and return the result it must produce.
  function automatic console_resp_t apply_request(input console_req_t req);
    console_resp_t resp;
    resp.read_char = '0;
    resp.read_attr = '0;
    resp.status    = ST_OK;
    case (req.kind)
      KIND_PUT:  apply_put(req.char_code, req.attr);
      KIND_READ: begin
        if (fetch_glyph(req.pos_x, req.pos_y, resp.read_char, resp.read_attr) != LOOKUP_OK)
          resp.status = ST_RANGE;
      end
      KIND_CLEAR: begin
        for (int y = 0; y < LOGICAL_ROWS; y++)
          for (int x = 0; x < LOGICAL_COLS; x++)
            void'(store_glyph(req.char_code, req.attr, x, y));
      end
      default: begin
        if (!store_glyph(req.char_code, req.attr, req.pos_x, req.pos_y)) resp.status = ST_RANGE;
      end
    endcase
    resp.col = cur_col[5:0];
    resp.row = cur_row[5:0];
    return resp;
  endfunction

  // True when this put would push the screen up from the current cursor.
  function automatic bit causes_scroll(input console_req_t req);
    if (req.kind != KIND_PUT || cur_row != LOGICAL_ROWS - 1) return 1'b0;
    if (req.char_code == CH_NL) return 1'b1;
    if (req.char_code == CH_CR || req.char_code == CH_BS) return 1'b0;
    return cur_col >= LOGICAL_COLS;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched with the oldest expectation.
  // Sampling right after the edge sees the pre-edge values the DUT drove.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    console_resp_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result: char %h attr %h col %0d row %0d status %0b",
                   $time, out_read_char, out_read_attr, out_cursor_col_out,
                   out_cursor_row_out, out_status);
      end else begin
        want = expected_results.pop_front();
        if (out_read_char !== want.read_char || out_read_attr !== want.read_attr ||
            out_cursor_col_out !== want.col || out_cursor_row_out !== want.row ||
            out_status !== want.status) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"[%0t] mismatch: exp char %h attr %h col %0d row %0d status %0b",
                      " / got char %h attr %h col %0d row %0d status %0b"},
                     $time, want.read_char, want.read_attr, want.col, want.row,
                     want.status, out_read_char, out_read_attr, out_cursor_col_out,
                     out_cursor_row_out, out_status);
        end
      end
    end
  end

  // Watchdog: a lost result or a stuck busy ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // Drop start and hold the channel quiet; n sets how long.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Present one request at the falling edge and hold it until taken. Start is
  // left high after the accepting edge; the next request or an idle cycle
  // overwrites it at the next falling edge, so it never toggles within a step.
  task automatic send_request(input console_req_t req);
    if (sender_gaps && $urandom_range(99) < IDLE_PERCENT) idle_cycles($urandom_range(1, MAX_GAP));
    @(negedge clk);
    start        = 1'b1;
    in_kind      = req.kind;
    in_char_code = req.char_code;
    in_attr_in   = req.attr;
    in_pos_x     = req.pos_x;
    in_pos_y     = req.pos_y;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_request(req));
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic wait_all_results();
    idle_cycles(1);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Ignored fields carry random values so their bits still toggle.
  task automatic do_put(input logic [7:0] c, input logic [7:0] a);
    console_req_t req;
    req = '{KIND_PUT, c, a, 8'($urandom_range(255)), 8'($urandom_range(255))};
    send_request(req);
  endtask

  task automatic do_read(input logic [7:0] x, input logic [7:0] y);
    console_req_t req;
    req = '{KIND_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), x, y};
    send_request(req);
  endtask

  task automatic do_write(input logic [7:0] c, input logic [7:0] a,
                          input logic [7:0] x, input logic [7:0] y);
    console_req_t req;
    req = '{KIND_WRITE, c, a, x, y};
    send_request(req);
  endtask

  task automatic do_clear(input logic [7:0] c, input logic [7:0] a);
    console_req_t req;
    req = '{KIND_CLEAR, c, a, 8'($urandom_range(255)), 8'($urandom_range(255))};
    send_request(req);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // The reset sweep must leave zero cells in both raw halves.
  task automatic test_reset_state();
    do_read(8'd0, 8'd0);
    do_read(8'(LOGICAL_COLS - 1), 8'(LOGICAL_ROWS - 1));
    wait_all_results();
  endtask

  // Corners, the fold boundary, attribute extremes, and out-of-range access.
  task automatic test_cell_access();
    do_write(8'hFF, 8'h00, 8'd0, 8'd0);
    do_write(8'h00, 8'hFF, 8'(LOGICAL_COLS - 1), 8'(RAW_ROWS - 1));
    do_write(8'h41, 8'h5A, 8'd0, 8'(RAW_ROWS));
    do_write(8'h7E, 8'hC3, 8'(LOGICAL_COLS - 1), 8'(LOGICAL_ROWS - 1));
    do_write(8'h55, 8'h55, 8'(LOGICAL_COLS), 8'd0);
    do_write(8'hAA, 8'hAA, 8'd0, 8'(LOGICAL_ROWS));
    do_read(8'd0, 8'd0);
    do_read(8'(LOGICAL_COLS - 1), 8'(RAW_ROWS - 1));
    do_read(8'd0, 8'(RAW_ROWS));
    do_read(8'(LOGICAL_COLS - 1), 8'(LOGICAL_ROWS - 1));
    do_read(8'hFF, 8'hFF);
    do_read(8'(LOGICAL_COLS), 8'd3);
    wait_all_results();
  endtask

  // Tabs, return, backspace with row wrap, and the deferred wrap at the edge.
  task automatic test_control_codes();
    do_put(8'h00, 8'hFF);                  // byte 0 prints like any glyph
    do_put(CH_TAB, 8'h17);
    do_put(8'hFF, 8'h00);
    do_put(CH_TAB, 8'h17);
    do_put(CH_BS, 8'h2E);
    do_put(CH_CR, 8'h00);
    do_put(CH_BS, 8'h3D);                  // top-left: column wraps, row stays
    do_put(8'h78, 8'h4C);                  // column now rests one past the edge
    do_read(8'(LOGICAL_COLS - 1), 8'd0);
    do_put(8'h79, 8'h5B);                  // wraps first, then prints
    do_put(CH_BS, 8'h6A);
    do_put(CH_BS, 8'h79);                  // back up onto the previous row
    do_put(CH_TAB, 8'h88);                 // single space to the edge
    do_put(CH_TAB, 8'h97);                 // wraps, then four spaces
    do_put(CH_NL, 8'hA6);
    do_read(8'd0, 8'd1);
    wait_all_results();
  endtask

  task automatic test_clear();
    do_clear(8'hAA, 8'hC3);
    do_read(8'd5, 8'd30);
    do_read(8'd5, 8'd3);
    do_clear(8'h20, 8'h07);
    do_read(8'(LOGICAL_COLS - 1), 8'(LOGICAL_ROWS - 1));
    wait_all_results();
  endtask

  // Walk to the last row, mark cells on both sides of the fold, then scroll by
  // line feed and by deferred wrap and check the markers moved up.
  task automatic test_scroll();
    while (cur_row != LOGICAL_ROWS - 1) do_put(CH_NL, 8'h07);
    do_write(8'h4D, 8'h12, 8'd3, 8'(RAW_ROWS));
    do_write(8'h4E, 8'h34, 8'd3, 8'(RAW_ROWS - 1));
    do_write(8'h4F, 8'hF0, 8'd7, 8'(LOGICAL_ROWS - 1));
    do_put(CH_NL, 8'hE1);
    do_read(8'd3, 8'(RAW_ROWS - 1));
    do_read(8'd3, 8'(RAW_ROWS - 2));
    do_read(8'd7, 8'(LOGICAL_ROWS - 2));
    do_read(8'd0, 8'(LOGICAL_ROWS - 1));
    repeat (LOGICAL_COLS / TAB_STOP) do_put(CH_TAB, 8'h1F);
    do_put(8'h5A, 8'h9C);
    do_read(8'd0, 8'(LOGICAL_ROWS - 1));
    do_read(8'd0, 8'(LOGICAL_ROWS - 2));
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------
  // Mostly in range so reads hit written cells; the rest spans the full byte.
  function automatic logic [7:0] random_pos(input int span);
    if ($urandom_range(99) < 80) return 8'($urandom_range(span - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic console_req_t random_request();
    console_req_t req;
    int           pick;
    req.char_code = 8'($urandom_range(255));
    req.attr      = 8'($urandom_range(255));
    req.pos_x     = random_pos(LOGICAL_COLS);
    req.pos_y     = random_pos(LOGICAL_ROWS);
    pick = $urandom_range(99);
    if (pick < 1 && clears_left > 0) begin
      req.kind = KIND_CLEAR;
      clears_left--;
    end else if (pick < 22) begin
      req.kind = KIND_READ;
    end else if (pick < 42) begin
      req.kind = KIND_WRITE;
    end else begin
      req.kind = KIND_PUT;
      pick = $urandom_range(99);
      if (pick < 10) req.char_code = CH_NL;
      else if (pick < 18) req.char_code = CH_CR;
      else if (pick < 28) req.char_code = CH_TAB;
      else if (pick < 40) req.char_code = CH_BS;
      // once the scroll allowance is spent, a return takes its place and keeps the cursor on its row
      if (causes_scroll(req)) begin
        if (scrolls_left > 0) scrolls_left--;
        else req.char_code = CH_CR;
      end
    end
    return req;
  endfunction

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_gaps = !(i >= QUIET_FIRST && i < QUIET_LAST);
      if (i % PAUSE_EVERY == PAUSE_EVERY - 1) wait_all_results();
      send_request(random_request());
    end
    sender_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    cur_col = 0;
    cur_row = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_cell_access();
    test_control_codes();
    test_clear();
    test_scroll();
    test_random_traffic();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== text_console_writer_top.f =====
hdl/tcw_pkg.sv
hdl/tcw_cell_store.sv
hdl/text_console_writer_top.sv
dv/tb_top.sv
